// ----- rtl/core/swpr_pkg.sv -----
// package for the stop-and-wait packet receiver
// holds field widths, command and result codes, and controller/datapath structs
// no dependencies
package swpr_pkg;

  localparam int unsigned MAX_PAYLOAD_DEF = 32;

  localparam int unsigned CMD_W   = 2;
  localparam int unsigned PTYPE_W = 3;
  localparam int unsigned LEN_W   = 6;
  localparam int unsigned CSUM_W  = 32;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned KIND_W  = 3;
  localparam int unsigned PROD_W  = 15;

  localparam logic [CMD_W-1:0] CMD_HEADER = 2'd0;
  localparam logic [CMD_W-1:0] CMD_BYTE   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_LOST   = 2'd2;
  localparam logic [CMD_W-1:0] CMD_NONE   = 2'd3;

  localparam logic [PTYPE_W-1:0] PT_DATA = 3'd0;
  localparam logic [PTYPE_W-1:0] PT_LAST = 3'd1;
  localparam logic [PTYPE_W-1:0] PT_ACK  = 3'd2;
  localparam logic [PTYPE_W-1:0] PT_NACK = 3'd3;
  localparam logic [PTYPE_W-1:0] PT_TERM = 3'd4;

  localparam logic [KIND_W-1:0] KIND_ACK    = 3'd0;
  localparam logic [KIND_W-1:0] KIND_NACK   = 3'd1;
  localparam logic [KIND_W-1:0] KIND_BYTE   = 3'd2;
  localparam logic [KIND_W-1:0] KIND_END    = 3'd3;
  localparam logic [KIND_W-1:0] KIND_REPLY  = 3'd4;
  localparam logic [KIND_W-1:0] KIND_CLOSED = 3'd5;

  typedef struct packed {
    logic              capture;
    logic              open_pkt;
    logic              clear_pkt;
    logic              set_closed;
    logic              acc_byte;
    logic              rel_start;
    logic              rel_next;
    logic              emit;
    logic [KIND_W-1:0] kind;
    logic              nack;
    logic              eom;
    logic              last;
  } ctrl_cmd_t;

  typedef struct packed {
    logic               closed;
    logic               in_packet;
    logic [CMD_W-1:0]   cmd;
    logic [PTYPE_W-1:0] ptype;
    logic               len_zero;
    logic               len_over;
    logic               csum_zero;
    logic               last_byte;
    logic               sum_match;
    logic               final_pkt;
    logic               rel_last;
    logic               slot_free;
  } ctrl_sts_t;

endpackage

// ----- rtl/core/swpr_ctrl.sv -----
// controller state machine of the stop-and-wait packet receiver
// sequences decode, checksum check and byte release; uses swpr_pkg
module swpr_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  swpr_pkg::ctrl_sts_t sts_i,
  output swpr_pkg::ctrl_cmd_t cmd_o
);
  import swpr_pkg::*;

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_DECODE  = 3'd1;
  localparam logic [2:0] S_CHECK   = 3'd2;
  localparam logic [2:0] S_READ    = 3'd3;
  localparam logic [2:0] S_RELEASE = 3'd4;
  localparam logic [2:0] S_EMPTY   = 3'd5;

  logic [2:0] state_q, state_d;

  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_DECODE;
        end
      end
      S_DECODE: begin
        if (sts_i.closed || sts_i.cmd == CMD_NONE) begin
          state_d = S_IDLE;
        end else if (sts_i.cmd == CMD_LOST ||
                     (sts_i.cmd == CMD_HEADER && sts_i.ptype == PT_TERM)) begin
          if (sts_i.slot_free) begin
            cmd_o.emit       = 1'b1;
            cmd_o.kind       = KIND_CLOSED;
            cmd_o.last       = 1'b1;
            cmd_o.set_closed = 1'b1;
            cmd_o.clear_pkt  = 1'b1;
            state_d          = S_IDLE;
          end
        end else if (sts_i.cmd == CMD_HEADER) begin
          if (sts_i.ptype inside {PT_ACK, PT_NACK}) begin
            if (sts_i.slot_free) begin
              cmd_o.emit      = 1'b1;
              cmd_o.kind      = KIND_REPLY;
              cmd_o.nack      = (sts_i.ptype == PT_NACK);
              cmd_o.last      = 1'b1;
              cmd_o.clear_pkt = 1'b1;
              state_d         = S_IDLE;
            end
          end else if (sts_i.ptype inside {PT_DATA, PT_LAST}) begin
            if (sts_i.len_over || (sts_i.len_zero && !sts_i.csum_zero)) begin
              if (sts_i.slot_free) begin
                cmd_o.emit      = 1'b1;
                cmd_o.kind      = KIND_NACK;
                cmd_o.last      = 1'b1;
                cmd_o.clear_pkt = 1'b1;
                state_d         = S_IDLE;
              end
            end else if (sts_i.len_zero) begin
              if (sts_i.slot_free) begin
                cmd_o.emit      = 1'b1;
                cmd_o.kind      = KIND_ACK;
                cmd_o.last      = (sts_i.ptype != PT_LAST);
                cmd_o.clear_pkt = 1'b1;
                state_d         = (sts_i.ptype == PT_LAST) ? S_EMPTY : S_IDLE;
              end
            end else begin
              cmd_o.open_pkt = 1'b1;
              state_d        = S_IDLE;
            end
          end else begin
            cmd_o.clear_pkt = 1'b1;
            state_d         = S_IDLE;
          end
        end else begin
          if (sts_i.in_packet) begin
            cmd_o.acc_byte = 1'b1;
            state_d        = sts_i.last_byte ? S_CHECK : S_IDLE;
          end else begin
            state_d = S_IDLE;
          end
        end
      end
      S_CHECK: begin
        if (sts_i.slot_free) begin
          cmd_o.emit = 1'b1;
          if (sts_i.sum_match) begin
            cmd_o.kind      = KIND_ACK;
            cmd_o.rel_start = 1'b1;
            state_d         = S_READ;
          end else begin
            cmd_o.kind = KIND_NACK;
            cmd_o.last = 1'b1;
            state_d    = S_IDLE;
          end
        end
      end
      S_READ: begin
        state_d = S_RELEASE;
      end
      S_RELEASE: begin
        if (sts_i.slot_free) begin
          cmd_o.emit     = 1'b1;
          cmd_o.kind     = KIND_BYTE;
          cmd_o.eom      = sts_i.final_pkt && sts_i.rel_last;
          cmd_o.last     = sts_i.rel_last;
          cmd_o.rel_next = 1'b1;
          state_d        = sts_i.rel_last ? S_IDLE : S_READ;
        end
      end
      S_EMPTY: begin
        if (sts_i.slot_free) begin
          cmd_o.emit = 1'b1;
          cmd_o.kind = KIND_END;
          cmd_o.last = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ----- rtl/core/swpr_dpath.sv -----
// datapath of the stop-and-wait packet receiver
// input capture, checksum, payload buffer, release counter and output register; uses swpr_pkg
module swpr_dpath #(
  parameter int unsigned MAX_PAYLOAD = swpr_pkg::MAX_PAYLOAD_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  swpr_pkg::ctrl_cmd_t                  cmd_i,
  output swpr_pkg::ctrl_sts_t                  sts_o,
  input  logic [swpr_pkg::CMD_W-1:0]           command_i,
  input  logic [swpr_pkg::PTYPE_W-1:0]         packet_type_i,
  input  logic [swpr_pkg::LEN_W-1:0]           pkt_len_i,
  input  logic signed [swpr_pkg::CSUM_W-1:0]   packet_checksum_i,
  input  logic [swpr_pkg::BYTE_W-1:0]          payload_byte_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic [swpr_pkg::KIND_W-1:0]          kind_o,
  output logic                                 reply_was_nack_o,
  output logic [swpr_pkg::BYTE_W-1:0]          message_byte_o,
  output logic                                 end_of_message_o,
  output logic                                 last_of_run_o
);
  import swpr_pkg::*;

  localparam int unsigned IDX_W = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

  logic [CMD_W-1:0]          cmd_q;
  logic [PTYPE_W-1:0]        ptype_q;
  logic [LEN_W-1:0]          plen_q;
  logic signed [CSUM_W-1:0]  pcsum_q;
  logic [BYTE_W-1:0]         byte_q;
  logic signed [PROD_W-1:0]  prod_q, prod_d;

  logic                      closed_q;
  logic                      in_packet_q;
  logic                      final_q;
  logic [LEN_W-1:0]          bytes_seen_q;
  logic [LEN_W-1:0]          expected_q;
  logic signed [CSUM_W-1:0]  running_sum_q;
  logic signed [CSUM_W-1:0]  carried_q;
  logic [LEN_W-1:0]          rd_cnt_q;

  logic [BYTE_W-1:0]         store [MAX_PAYLOAD];
  logic [BYTE_W-1:0]         rd_data_q;

  logic                      out_valid_q;
  logic [KIND_W-1:0]         kind_q;
  logic                      nack_q;
  logic [BYTE_W-1:0]         msg_q;
  logic                      eom_q;
  logic                      last_q;

  logic                      slot_free;
  logic [LEN_W-1:0]          bytes_next;
  logic [LEN_W-1:0]          rd_next;

  // even positions weight the signed byte by its index
  always_comb begin
    if (bytes_seen_q[0]) begin
      prod_d = PROD_W'($signed(payload_byte_i));
    end else begin
      prod_d = $signed({1'b0, bytes_seen_q}) * $signed(payload_byte_i);
    end
  end

  assign bytes_next = bytes_seen_q + LEN_W'(1);
  assign rd_next    = rd_cnt_q + LEN_W'(1);
  assign slot_free  = !out_valid_q || !out_stall_i;

  always_comb begin
    sts_o.closed    = closed_q;
    sts_o.in_packet = in_packet_q;
    sts_o.cmd       = cmd_q;
    sts_o.ptype     = ptype_q;
    sts_o.len_zero  = (plen_q == '0);
    sts_o.len_over  = (plen_q > LEN_W'(MAX_PAYLOAD));
    sts_o.csum_zero = (pcsum_q == '0);
    sts_o.last_byte = (bytes_next == expected_q);
    sts_o.sum_match = (running_sum_q == carried_q);
    sts_o.final_pkt = final_q;
    sts_o.rel_last  = (rd_next == expected_q);
    sts_o.slot_free = slot_free;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      cmd_q   <= command_i;
      ptype_q <= packet_type_i;
      plen_q  <= pkt_len_i;
      pcsum_q <= packet_checksum_i;
      byte_q  <= payload_byte_i;
      prod_q  <= prod_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.acc_byte) begin
      store[bytes_seen_q[IDX_W-1:0]] <= byte_q;
    end
    rd_data_q <= store[rd_cnt_q[IDX_W-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      closed_q      <= 1'b0;
      in_packet_q   <= 1'b0;
      final_q       <= 1'b0;
      bytes_seen_q  <= '0;
      expected_q    <= '0;
      running_sum_q <= '0;
      carried_q     <= '0;
      rd_cnt_q      <= '0;
    end else begin
      if (cmd_i.set_closed) begin
        closed_q <= 1'b1;
      end
      if (cmd_i.clear_pkt) begin
        in_packet_q <= 1'b0;
      end
      if (cmd_i.open_pkt) begin
        in_packet_q   <= 1'b1;
        expected_q    <= plen_q;
        bytes_seen_q  <= '0;
        running_sum_q <= '0;
        carried_q     <= pcsum_q;
        final_q       <= (ptype_q == PT_LAST);
      end
      if (cmd_i.acc_byte) begin
        running_sum_q <= running_sum_q + CSUM_W'(prod_q);
        bytes_seen_q  <= bytes_next;
        if (bytes_next == expected_q) begin
          in_packet_q <= 1'b0;
        end
      end
      if (cmd_i.rel_start) begin
        rd_cnt_q <= '0;
      end else if (cmd_i.rel_next) begin
        rd_cnt_q <= rd_next;
      end
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      kind_q <= cmd_i.kind;
      nack_q <= cmd_i.nack;
      msg_q  <= (cmd_i.kind == KIND_BYTE) ? rd_data_q : '0;
      eom_q  <= cmd_i.eom;
      last_q <= cmd_i.last;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign kind_o           = kind_q;
  assign reply_was_nack_o = nack_q;
  assign message_byte_o   = msg_q;
  assign end_of_message_o = eom_q;
  assign last_of_run_o    = last_q;

endmodule

// ----- rtl/core/stop_and_wait_packet_receiver_unit.sv -----
// top level of the stop-and-wait packet receiver
// joins swpr_ctrl and swpr_dpath; uses swpr_pkg
//
//   channel   direction  handshake                 payload
//   in        input      in_valid_i / in_stall_o   command, packet_type, pkt_len,
//                                                  packet_checksum, payload_byte
//   out       output     out_valid_o / out_stall_i kind, reply_was_nack, message_byte,
//                                                  end_of_message, last_of_run
//
// one item at a time: an item is captured, then decoded, before the next is taken
// a good packet adds an ack result, then releases each byte by a buffer read and an output load
// output register lets the last result wait while the next item is taken
// out_stall_i holds the controller in place until the output register frees
// reset is asynchronous; buffer contents are left as they are
module stop_and_wait_packet_receiver_unit #(
  parameter int unsigned MAX_PAYLOAD = swpr_pkg::MAX_PAYLOAD_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic [swpr_pkg::CMD_W-1:0]           command_i,
  input  logic [swpr_pkg::PTYPE_W-1:0]         packet_type_i,
  input  logic [swpr_pkg::LEN_W-1:0]           pkt_len_i,
  input  logic signed [swpr_pkg::CSUM_W-1:0]   packet_checksum_i,
  input  logic [swpr_pkg::BYTE_W-1:0]          payload_byte_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic [swpr_pkg::KIND_W-1:0]          kind_o,
  output logic                                 reply_was_nack_o,
  output logic [swpr_pkg::BYTE_W-1:0]          message_byte_o,
  output logic                                 end_of_message_o,
  output logic                                 last_of_run_o
);
  import swpr_pkg::*;

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  swpr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  swpr_dpath #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_dpath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .command_i         (command_i),
    .packet_type_i     (packet_type_i),
    .pkt_len_i         (pkt_len_i),
    .packet_checksum_i (packet_checksum_i),
    .payload_byte_i    (payload_byte_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .kind_o            (kind_o),
    .reply_was_nack_o  (reply_was_nack_o),
    .message_byte_o    (message_byte_o),
    .end_of_message_o  (end_of_message_o),
    .last_of_run_o     (last_of_run_o)
  );

endmodule

// ----- rtl/core/swpr_chk.sv -----
// port checker for the stop-and-wait packet receiver, bound to the top level
// watches result fields and output handshake; uses swpr_pkg
module swpr_chk (
  input logic                                 clk_i,
  input logic                                 rst_ni,
  input logic                                 in_valid_i,
  input logic                                 in_stall_o,
  input logic [swpr_pkg::CMD_W-1:0]           command_i,
  input logic [swpr_pkg::PTYPE_W-1:0]         packet_type_i,
  input logic [swpr_pkg::LEN_W-1:0]           pkt_len_i,
  input logic signed [swpr_pkg::CSUM_W-1:0]   packet_checksum_i,
  input logic [swpr_pkg::BYTE_W-1:0]          payload_byte_i,
  input logic                                 out_valid_o,
  input logic                                 out_stall_i,
  input logic [swpr_pkg::KIND_W-1:0]          kind_o,
  input logic                                 reply_was_nack_o,
  input logic [swpr_pkg::BYTE_W-1:0]          message_byte_o,
  input logic                                 end_of_message_o,
  input logic                                 last_of_run_o
);
  import swpr_pkg::*;

  logic unused_in;
  assign unused_in = in_valid_i ^ in_stall_o ^ ^command_i ^ ^packet_type_i ^
                     ^pkt_len_i ^ ^packet_checksum_i ^ ^payload_byte_i;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(kind_o) &&
      $stable(message_byte_o) && $stable(last_of_run_o))
    else $error("stalled result changed");

  a_eom_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && end_of_message_o |-> kind_o == KIND_BYTE && last_of_run_o)
    else $error("end of message not on last released byte");

  a_byte_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o != KIND_BYTE |-> message_byte_o == '0 && !end_of_message_o)
    else $error("byte fields set on a non-byte result");

  a_closed_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (kind_o == KIND_CLOSED || kind_o == KIND_REPLY ||
      kind_o == KIND_NACK || kind_o == KIND_END) |-> last_of_run_o)
    else $error("single-result item not marked last");

  a_nack_reply: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && reply_was_nack_o |-> kind_o == KIND_REPLY)
    else $error("nack flag outside a reply result");

endmodule

bind stop_and_wait_packet_receiver_unit swpr_chk u_swpr_chk (.*);
